>>> hdl/lce_pkg.sv
package lce_pkg;

    // field and register widths
    localparam int PIX_W       = 8;
    localparam int COEF_W      = 16;
    localparam int NUM_COEF    = 5;
    localparam int COEF_IDX_W  = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int HALF_W      = 2;

    // defaults
    localparam int MAX_TAPS_DEF    = 5;
    localparam int QUEUE_DEPTH_DEF = 4;

    // arithmetic widths, sized for up to five taps
    localparam int PROD_W = COEF_W + PIX_W + 1;
    localparam int ACC_W  = 28;
    localparam int WACC_W = 19;
    localparam int NUM_W  = 30;
    localparam int DEN_W  = 21;
    localparam int QUO_W  = 9;
    localparam int STEP_W = 4;
    localparam int EXT_W  = NUM_W + QUO_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_4   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_HALF = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_MODE = 3'd6;

    localparam logic [COEF_W-1:0] COEF_RESET = 16'd4096;
    localparam logic [HALF_W-1:0] HALF_RESET = 2'd1;

    // configuration seen by the back end
    typedef struct packed {
        logic [NUM_COEF-1:0][COEF_W-1:0] coef;
        logic [HALF_W-1:0]               h;
        logic                            mode;
    } cfg_t;

    // queue status
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEL,
        ST_MAC,
        ST_PREP,
        ST_DIV,
        ST_OUT
    } bk_state_t;

endpackage

>>> hdl/lce_front.sv
module lce_front #(
    parameter int MAX_TAPS = lce_pkg::MAX_TAPS_DEF,
    parameter int IDX_W    = $clog2(MAX_TAPS),
    parameter int REC_W    = MAX_TAPS * lce_pkg::PIX_W + IDX_W + 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [lce_pkg::PIX_W-1:0] pixel_in,
    input  logic                      last_in_line,
    output logic                      push,
    output logic [REC_W-1:0]          rec
);

    logic [MAX_TAPS-1:0][lce_pkg::PIX_W-1:0] win_reg;
    logic [MAX_TAPS-1:0][lce_pkg::PIX_W-1:0] win_shift;
    logic [IDX_W-1:0]                        seen_reg;
    logic [IDX_W-1:0]                        seen_next;

    assign push = in_valid && in_ready;

    // window shifted by the new pixel, newest first
    always_comb
    begin
        win_shift[0] = pixel_in;
        for (int i = 1; i < MAX_TAPS; i++)
        begin
            win_shift[i] = win_reg[i-1];
        end
    end

    assign rec = {last_in_line, seen_reg, win_shift};

    // position within the line, saturating
    always_comb
    begin
        seen_next = seen_reg;
        if (last_in_line)
        begin
            seen_next = '0;
        end
        else if (seen_reg < IDX_W'(MAX_TAPS - 1))
        begin
            seen_next = seen_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= '0;
            seen_reg <= '0;
        end
        else if (push)
        begin
            win_reg  <= last_in_line ? '0 : win_shift;
            seen_reg <= seen_next;
        end
    end

endmodule

>>> hdl/lce_queue.sv
module lce_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lce_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [WIDTH-1:0]    wr_data,
    input  logic                pop,
    output logic [WIDTH-1:0]    rd_data,
    output lce_pkg::q_stat_t    stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_data    = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> hdl/lce_back.sv
module lce_back #(
    parameter int MAX_TAPS = lce_pkg::MAX_TAPS_DEF,
    parameter int IDX_W    = $clog2(MAX_TAPS),
    parameter int REC_W    = MAX_TAPS * lce_pkg::PIX_W + IDX_W + 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lce_pkg::cfg_t             cfg,
    input  lce_pkg::q_stat_t          q_stat,
    input  logic [REC_W-1:0]          rec,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [lce_pkg::PIX_W-1:0] pixel_out,
    output logic                      line_end,
    output logic                      zero_weight
);

    localparam int HMAX = (MAX_TAPS - 1) / 2;
    localparam int H_W  = $clog2(HMAX + 1);
    localparam int PW   = lce_pkg::PIX_W;

    lce_pkg::bk_state_t state_reg, state_next;

    logic [MAX_TAPS-1:0][PW-1:0]        win_reg;
    logic [IDX_W-1:0]                   p_reg;
    logic                               last_reg;
    logic [H_W-1:0]                     d_reg;
    logic [IDX_W-1:0]                   j_reg;
    logic signed [lce_pkg::ACC_W-1:0]   acc_reg;
    logic signed [lce_pkg::WACC_W-1:0]  wacc_reg;
    logic [lce_pkg::NUM_W-1:0]          rem_reg;
    logic [lce_pkg::DEN_W-1:0]          dv_reg;
    logic [lce_pkg::STEP_W-1:0]         k_reg;
    logic [lce_pkg::QUO_W-1:0]          q_reg;
    logic [PW-1:0]                      px_reg;
    logic                               zw_reg;
    logic                               out_valid_reg;
    logic [PW-1:0]                      pixel_out_reg;
    logic                               line_end_reg;
    logic                               zero_weight_reg;

    logic [H_W-1:0]                     h;
    logic [H_W-1:0]                     dmin;
    logic                               done;
    logic                               skip;
    logic                               copy;
    logic                               out_free;
    logic                               emit;
    logic                               advance;
    logic [IDX_W-1:0]                   d_ext;
    logic [IDX_W-1:0]                   h_ext;
    logic [IDX_W-1:0]                   dh;
    logic [IDX_W-1:0]                   twoh;
    logic [IDX_W-1:0]                   tap_i;
    logic                               tap_in;
    logic signed [lce_pkg::COEF_W-1:0]  coef;
    logic signed [lce_pkg::PROD_W-1:0]  prod;
    logic signed [lce_pkg::NUM_W-1:0]   n_s;
    logic signed [lce_pkg::NUM_W-1:0]   n_abs;
    logic signed [lce_pkg::DEN_W-1:0]   d_s;
    logic signed [lce_pkg::DEN_W-1:0]   d_abs;
    logic [lce_pkg::EXT_W-1:0]          trial;
    logic                               fits;
    logic [lce_pkg::QUO_W-1:0]          q_next;

    // job decode
    assign h     = H_W'(cfg.h);
    assign dmin  = last_reg ? '0 : h;
    assign done  = (d_reg == dmin);
    assign d_ext = IDX_W'(d_reg);
    assign h_ext = IDX_W'(h);
    assign dh    = d_ext + h_ext;
    assign twoh  = h_ext << 1;
    assign skip  = (d_ext > p_reg);
    assign copy  = cfg.mode && (((p_reg - d_ext) < h_ext) || (d_reg < h));

    // one tap per cycle
    assign tap_i  = dh - j_reg;
    assign tap_in = (dh >= j_reg) && (tap_i <= p_reg);
    assign coef   = $signed(cfg.coef[lce_pkg::COEF_IDX_W'(j_reg)]);
    assign prod   = coef * $signed({1'b0, win_reg[tap_i]});

    // rounding: floor((2*sum + wsum) / (2*wsum)) with a positive divisor
    assign n_s   = (lce_pkg::NUM_W'(acc_reg) <<< 1) + lce_pkg::NUM_W'(wacc_reg);
    assign d_s   = lce_pkg::DEN_W'(wacc_reg) <<< 1;
    assign n_abs = d_s[lce_pkg::DEN_W-1] ? -n_s : n_s;
    assign d_abs = d_s[lce_pkg::DEN_W-1] ? -d_s : d_s;

    // restoring divide step
    assign trial  = lce_pkg::EXT_W'(dv_reg) << k_reg;
    assign fits   = (lce_pkg::EXT_W'(rem_reg) >= trial);
    assign q_next = {q_reg[lce_pkg::QUO_W-2:0], fits};

    // handshake with queue and output register
    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;
        pop      = (state_reg == lce_pkg::ST_IDLE) && !q_stat.empty;
        emit     = (state_reg == lce_pkg::ST_OUT) && out_free;
        advance  = emit || ((state_reg == lce_pkg::ST_SEL) && skip);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lce_pkg::ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = lce_pkg::ST_SEL;
                end
            end
            lce_pkg::ST_SEL:
            begin
                if (skip)
                begin
                    state_next = done ? lce_pkg::ST_IDLE : lce_pkg::ST_SEL;
                end
                else if (copy)
                begin
                    state_next = lce_pkg::ST_OUT;
                end
                else
                begin
                    state_next = lce_pkg::ST_MAC;
                end
            end
            lce_pkg::ST_MAC:
            begin
                if (j_reg == twoh)
                begin
                    state_next = lce_pkg::ST_PREP;
                end
            end
            lce_pkg::ST_PREP:
            begin
                if ((wacc_reg == '0) || n_abs[lce_pkg::NUM_W-1])
                begin
                    state_next = lce_pkg::ST_OUT;
                end
                else
                begin
                    state_next = lce_pkg::ST_DIV;
                end
            end
            lce_pkg::ST_DIV:
            begin
                if (k_reg == '0)
                begin
                    state_next = lce_pkg::ST_OUT;
                end
            end
            lce_pkg::ST_OUT:
            begin
                if (emit)
                begin
                    state_next = done ? lce_pkg::ST_IDLE : lce_pkg::ST_SEL;
                end
            end
            default:
            begin
                state_next = lce_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lce_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            win_reg  <= rec[MAX_TAPS*PW-1:0];
            p_reg    <= rec[MAX_TAPS*PW +: IDX_W];
            last_reg <= rec[REC_W-1];
            d_reg    <= H_W'(cfg.h);
        end
        if (advance && !done)
        begin
            d_reg <= d_reg - 1'b1;
        end
        case (state_reg)
            lce_pkg::ST_SEL:
            begin
                px_reg   <= win_reg[d_ext];
                zw_reg   <= 1'b0;
                j_reg    <= '0;
                acc_reg  <= '0;
                wacc_reg <= '0;
            end
            lce_pkg::ST_MAC:
            begin
                if (tap_in)
                begin
                    acc_reg  <= acc_reg + lce_pkg::ACC_W'(prod);
                    wacc_reg <= wacc_reg + lce_pkg::WACC_W'(coef);
                end
                j_reg <= j_reg + 1'b1;
            end
            lce_pkg::ST_PREP:
            begin
                px_reg  <= '0;
                zw_reg  <= (wacc_reg == '0);
                rem_reg <= n_abs;
                dv_reg  <= d_abs;
                k_reg   <= lce_pkg::STEP_W'(lce_pkg::QUO_W - 1);
                q_reg   <= '0;
            end
            lce_pkg::ST_DIV:
            begin
                if (fits)
                begin
                    rem_reg <= rem_reg - lce_pkg::NUM_W'(trial);
                end
                q_reg <= q_next;
                k_reg <= k_reg - 1'b1;
                if (k_reg == '0)
                begin
                    px_reg <= q_next[lce_pkg::QUO_W-1] ? '1 : q_next[PW-1:0];
                end
            end
            default:
            begin
            end
        endcase
        if (emit)
        begin
            pixel_out_reg   <= px_reg;
            line_end_reg    <= last_reg && (d_reg == '0);
            zero_weight_reg <= zw_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_out   = pixel_out_reg;
    assign line_end    = line_end_reg;
    assign zero_weight = zero_weight_reg;

endmodule

>>> hdl/line_convolution_edge_modes.sv
// Streaming 1-D convolution of one line of 8-bit pixels with an odd kernel of
// 2*tap_half+1 signed taps (scale 1/4096), rounded half up and saturated to a
// byte; outputs lag the input by tap_half pixels and the pixel marked
// last_in_line flushes the rest of the line. The front end takes one pixel a
// cycle, while the queue is not full, into a four-entry queue; the back end
// fetches each transaction from the queue and then, per output, selects the
// centre, multiply-accumulates over the taps, prepares the divide, runs the
// restoring division one quotient bit at a time and issues the result. A
// copied edge pixel goes from select straight to issue, a zero divisor or a
// negative sum skips the division, and a centre before the line start gives
// no output; a new transaction is fetched only once the last one is done.
// The shared multiply-accumulate and bit-serial divider set the output rate.
// Configuration must be written only while the block is idle (not enforced).
module line_convolution_edge_modes #(
    parameter int MAX_TAPS    = lce_pkg::MAX_TAPS_DEF,
    parameter int QUEUE_DEPTH = lce_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [lce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lce_pkg::COEF_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [lce_pkg::PIX_W-1:0]      pixel_in,
    input  logic                           last_in_line,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [lce_pkg::PIX_W-1:0]      pixel_out,
    output logic                           line_end,
    output logic                           zero_weight
);

    localparam int HMAX  = (MAX_TAPS - 1) / 2;
    localparam int IDX_W = $clog2(MAX_TAPS);
    localparam int REC_W = MAX_TAPS * lce_pkg::PIX_W + IDX_W + 1;

    logic [lce_pkg::NUM_COEF-1:0][lce_pkg::COEF_W-1:0] coef_reg;
    logic [lce_pkg::HALF_W-1:0]  tap_half_reg;
    logic                        pad_mode_reg;
    lce_pkg::cfg_t               cfg;
    lce_pkg::q_stat_t            q_stat;
    logic                        push;
    logic                        pop;
    logic [REC_W-1:0]            rec_in;
    logic [REC_W-1:0]            rec_out;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lce_pkg::NUM_COEF; i++)
            begin
                coef_reg[i] <= lce_pkg::COEF_RESET;
            end
            tap_half_reg <= lce_pkg::HALF_RESET;
            pad_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                lce_pkg::REG_COEF_0:   coef_reg[0]  <= cfg_data;
                lce_pkg::REG_COEF_1:   coef_reg[1]  <= cfg_data;
                lce_pkg::REG_COEF_2:   coef_reg[2]  <= cfg_data;
                lce_pkg::REG_COEF_3:   coef_reg[3]  <= cfg_data;
                lce_pkg::REG_COEF_4:   coef_reg[4]  <= cfg_data;
                lce_pkg::REG_TAP_HALF: tap_half_reg <= cfg_data[lce_pkg::HALF_W-1:0];
                lce_pkg::REG_PAD_MODE: pad_mode_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // clamp half length to the kernel depth
    always_comb
    begin
        cfg.coef = coef_reg;
        cfg.h    = (tap_half_reg > lce_pkg::HALF_W'(HMAX)) ? lce_pkg::HALF_W'(HMAX)
                                                           : tap_half_reg;
        cfg.mode = pad_mode_reg;
    end

    assign in_stall = q_stat.full;

    lce_front #(
        .MAX_TAPS (MAX_TAPS),
        .IDX_W    (IDX_W),
        .REC_W    (REC_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (!q_stat.full),
        .pixel_in     (pixel_in),
        .last_in_line (last_in_line),
        .push         (push),
        .rec          (rec_in)
    );

    lce_queue #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (rec_in),
        .pop     (pop),
        .rd_data (rec_out),
        .stat    (q_stat)
    );

    lce_back #(
        .MAX_TAPS (MAX_TAPS),
        .IDX_W    (IDX_W),
        .REC_W    (REC_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_stat      (q_stat),
        .rec         (rec_out),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_out   (pixel_out),
        .line_end    (line_end),
        .zero_weight (zero_weight)
    );

    // queue cannot be full and empty at once
    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty together");

    // an accepted transaction is held in the queue on the next cycle
    a_push_held: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !q_stat.empty)
        else $error("queue empty after push");

    // zero divisor gives a zero pixel
    a_zero_weight: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_weight) |-> (pixel_out == '0))
        else $error("zero weight with non-zero pixel");

endmodule

>>> tb/tb_line_convolution_edge_modes.sv
`timescale 1ns / 1ps

module tb_line_convolution_edge_modes;

    localparam int WINDOW   = 5;
    localparam int LIMIT    = 20000;
    localparam int SETTLE   = 40;

    // one filtered pixel as it leaves the block
    typedef struct packed {
        logic [lce_pkg::PIX_W-1:0] pix;
        logic                      eol;
        logic                      zw;
    } conv_out_t;

    // directed stimulus row; chk set where the first result is typed in
    typedef struct {
        logic [lce_pkg::PIX_W-1:0] pix;
        logic                      last;
        logic                      chk;
        conv_out_t                 want;
    } stim_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_wr_en;
    logic [lce_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [lce_pkg::COEF_W-1:0]    cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    logic [lce_pkg::PIX_W-1:0]     pixel_in;
    logic                          last_in_line;
    logic                          out_valid;
    logic                          out_stall;
    logic [lce_pkg::PIX_W-1:0]     pixel_out;
    logic                          line_end;
    logic                          zero_weight;

    // predictor state
    logic signed [lce_pkg::COEF_W-1:0] kern [lce_pkg::NUM_COEF];
    logic [lce_pkg::HALF_W-1:0]        kern_half;
    logic                              edge_copy;
    logic [lce_pkg::PIX_W-1:0]         line_win [WINDOW];
    int unsigned                       line_pos;

    conv_out_t   pixel_fifo [$];
    int          errors;
    int          idle_cnt;
    int          send_idle;
    int          recv_idle;
    conv_out_t   directed_want;
    logic        directed_chk;

    line_convolution_edge_modes uut (.*);

    // clock
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    task automatic report(input string what, input conv_out_t got, input conv_out_t want);
        $display("error: %s got pix=%0d eol=%0b zw=%0b want pix=%0d eol=%0b zw=%0b",
                 what, got.pix, got.eol, got.zw, want.pix, want.eol, want.zw);
        errors++;
    endtask

    // half-up rounding of num/den, clamped to a byte
    function automatic logic [lce_pkg::PIX_W-1:0] round_clamp(longint num, longint den);
        longint n;
        longint d;
        longint q;
        n = 2 * num + den;
        d = 2 * den;
        if (d < 0)
        begin
            n = -n;
            d = -d;
        end
        q = n / d;
        if ((n % d != 0) && (n < 0))
            q = q - 1;
        if (q < 0)
            return '0;
        if (q > 255)
            return 8'd255;
        return q[lce_pkg::PIX_W-1:0];
    endfunction

    // convolve one accepted pixel and queue the outputs it releases
    task automatic convolve_pixel(input logic [lce_pkg::PIX_W-1:0] pix, input logic last);
        int unsigned h;
        int unsigned lo;
        int unsigned idx;
        longint      acc;
        longint      wsum;
        conv_out_t   res;
        h = (kern_half > 2) ? 2 : kern_half;
        for (int k = WINDOW - 1; k > 0; k--)
            line_win[k] = line_win[k-1];
        line_win[0] = pix;
        lo = last ? 0 : h;
        for (int d = h; d >= int'(lo); d--)
        begin
            if (d > line_pos)
                continue;
            res = '0;
            res.eol = last && (d == 0);
            if (edge_copy && ((line_pos - d) < h || d < h))
                res.pix = line_win[d];
            else
            begin
                acc = 0;
                wsum = 0;
                for (int j = 0; j <= 2 * h; j++)
                begin
                    if (d + h < j)
                        continue;
                    idx = d + h - j;
                    if (idx <= line_pos && idx < WINDOW)
                    begin
                        acc += longint'(kern[j]) * longint'(line_win[idx]);
                        wsum += longint'(kern[j]);
                    end
                end
                if (wsum == 0)
                    res.zw = 1'b1;
                else
                    res.pix = round_clamp(acc, wsum);
            end
            pixel_fifo.push_back(res);
        end
        if (last)
        begin
            foreach (line_win[k])
                line_win[k] = '0;
            line_pos = 0;
        end
        else if (line_pos < WINDOW - 1)
            line_pos++;
    endtask

    // register write, only while idle
    task automatic write_reg(input logic [lce_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lce_pkg::COEF_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx < lce_pkg::NUM_COEF)
            kern[idx] = val;
        else if (idx == lce_pkg::REG_TAP_HALF)
            kern_half = val[lce_pkg::HALF_W-1:0];
        else if (idx == lce_pkg::REG_PAD_MODE)
            edge_copy = val[0];
    endtask

    // stop sending and wait until every expected output has left
    task automatic drain_wait();
        int n;
        n = 0;
        in_valid <= 1'b0;
        while (pixel_fifo.size() != 0 && n < LIMIT)
        begin
            @(negedge clk);
            n++;
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_kernel(input int c0, input int c1, input int c2, input int c3,
                              input int c4, input int h, input int mode);
        drain_wait();
        write_reg(lce_pkg::REG_COEF_0, c0[lce_pkg::COEF_W-1:0]);
        write_reg(lce_pkg::REG_COEF_1, c1[lce_pkg::COEF_W-1:0]);
        write_reg(lce_pkg::REG_COEF_2, c2[lce_pkg::COEF_W-1:0]);
        write_reg(lce_pkg::REG_COEF_3, c3[lce_pkg::COEF_W-1:0]);
        write_reg(lce_pkg::REG_COEF_4, c4[lce_pkg::COEF_W-1:0]);
        write_reg(lce_pkg::REG_TAP_HALF, h[lce_pkg::COEF_W-1:0]);
        write_reg(lce_pkg::REG_PAD_MODE, mode[lce_pkg::COEF_W-1:0]);
    endtask

    // send one pixel; valid stays high across back-to-back transactions
    task automatic send_pixel(input logic [lce_pkg::PIX_W-1:0] pix, input logic last);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        pixel_in     <= pix;
        last_in_line <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        convolve_pixel(pix, last);
        @(negedge clk);
    endtask

    // random lines, mostly short and well formed
    task automatic random_lines(input int count);
        int len;
        int k;
        k = 0;
        while (k < count)
        begin
            len = $urandom_range(6) + 1;
            if ($urandom_range(9) == 0)
                len = $urandom_range(14) + 1;
            for (int p = 0; p < len; p++)
            begin
                send_pixel($urandom_range(7) == 0 ? 8'hff : 8'($urandom),
                           p == len - 1);
                k++;
            end
        end
    endtask

    // receiver: stall, compare each transaction with the oldest expectation
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);
    end

    always @(posedge clk)
    begin
        conv_out_t got;
        conv_out_t want;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cnt <= 0;
            else
                idle_cnt <= idle_cnt + 1;
            if (out_valid && !out_stall)
            begin
                got = '{pixel_out, line_end, zero_weight};
                if (pixel_fifo.size() == 0)
                    report("unexpected output", got, got);
                else
                begin
                    want = pixel_fifo.pop_front();
                    if (directed_chk && got !== directed_want)
                        report("directed", got, directed_want);
                    else if (got !== want)
                        report("output", got, want);
                    directed_chk <= 1'b0;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (idle_cnt >= LIMIT)
        begin
            $display("line_convolution_edge_modes: mismatch");
            $finish;
        end
    end

    stim_row_t directed_rows [] = '{
        // single pixel line, default box of three equal taps
        '{8'd200, 1'b1, 1'b1, '{8'd200, 1'b1, 1'b0}},
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd255, 1'b0, 1'b0, '0},
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd255, 1'b1, 1'b0, '0},
        '{8'd255, 1'b0, 1'b1, '{8'd255, 1'b0, 1'b0}},
        '{8'd255, 1'b0, 1'b0, '0},
        '{8'd255, 1'b0, 1'b0, '0},
        '{8'd1,   1'b0, 1'b0, '0},
        '{8'd128, 1'b1, 1'b0, '0}
    };

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        pixel_in     = '0;
        last_in_line = 1'b0;
        out_stall    = 1'b0;
        errors       = 0;
        idle_cnt     = 0;
        send_idle    = 0;
        recv_idle    = 0;
        directed_chk = 1'b0;
        directed_want = '0;
        foreach (kern[k])
            kern[k] = lce_pkg::COEF_RESET;
        kern_half = lce_pkg::HALF_RESET;
        edge_copy = 1'b0;
        foreach (line_win[k])
            line_win[k] = '0;
        line_pos = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part under reset settings
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].chk)
            begin
                drain_wait();
                directed_want = directed_rows[r].want;
                directed_chk  = 1'b1;
            end
            send_pixel(directed_rows[r].pix, directed_rows[r].last);
        end

        // zero tap sum, extreme taps, oversized half length, edge copy
        set_kernel(4096, -4096, 0, 0, 0, 1, 0);
        for (int p = 0; p < 4; p++)
            send_pixel(8'(p * 60), p == 3);
        set_kernel(32767, -32768, 32767, -32768, 32767, 3, 1);
        for (int p = 0; p < 7; p++)
            send_pixel(8'($urandom), p == 6);
        set_kernel(100, 200, 300, 0, 0, 0, 1);
        send_pixel(8'hff, 1'b0);
        send_pixel(8'h00, 1'b1);

        // random phases under several settings and idling patterns
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph / 2)
                0:
                begin
                    send_idle = 18;
                    recv_idle = 57;
                end
                1:
                begin
                    send_idle = 57;
                    recv_idle = 18;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            if (ph < 3)
                set_kernel($urandom_range(8192), $urandom_range(8192), $urandom_range(8192),
                           $urandom_range(8192), $urandom_range(8192),
                           $urandom_range(3), $urandom_range(1));
            else
                set_kernel(int'($urandom) % 32768, int'($urandom) % 32768,
                           int'($urandom) % 32768, int'($urandom) % 32768,
                           int'($urandom) % 32768, $urandom_range(3), ph % 2);
            random_lines(23);
        end

        send_idle = 0;
        recv_idle = 0;
        drain_wait();
        if (errors == 0 && pixel_fifo.size() == 0)
            $display("line_convolution_edge_modes: match");
        else
            $display("line_convolution_edge_modes: mismatch");
        $finish;
    end

endmodule
